[rtl/core/abt_pkg.sv]
// ----------------------------------------------------------------------------
// AABB build and transform: shared definitions
// Widths, register indexes, request classes and the queue head record that
// the front end hands to the back end.
// ----------------------------------------------------------------------------
package abt_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int COEF_WIDTH_DEF  = 16;

	localparam int CFG_WIDTH       = 48;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int OFFSET_WIDTH    = 32;
	localparam int COEF_STRIDE     = 16;
	localparam int AXES            = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ROW_X    = 3'd0,
		REG_ROW_Y    = 3'd1,
		REG_ROW_Z    = 3'd2,
		REG_OFFSET_X = 3'd3,
		REG_OFFSET_Y = 3'd4,
		REG_OFFSET_Z = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_EXTEND,
		OP_RESTART,
		OP_TRANSFORM
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} q_head_t;

endpackage

[rtl/core/abt_front.sv]
// ----------------------------------------------------------------------------
// AABB front end
// Accepts requests, classifies them and holds them in a short queue until
// the back end takes them.
// ----------------------------------------------------------------------------
module abt_front import abt_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic                          first_vertex,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	output q_head_t                       head,
	output logic signed [COORD_WIDTH-1:0] head_pos_x,
	output logic signed [COORD_WIDTH-1:0] head_pos_y,
	output logic signed [COORD_WIDTH-1:0] head_pos_z,
	input  logic                          pop
);

	logic [QUEUE_PTR_W:0]   count_q;
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;

	op_t                          op_q [QUEUE_DEPTH];
	logic signed [COORD_WIDTH-1:0] px_q [QUEUE_DEPTH];
	logic signed [COORD_WIDTH-1:0] py_q [QUEUE_DEPTH];
	logic signed [COORD_WIDTH-1:0] pz_q [QUEUE_DEPTH];

	op_t  op_in;
	logic push;

	assign in_ready = (count_q != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;

	// A transform ignores the vertex fields; a vertex either extends the box
	// or restarts it from empty.
	always_comb begin
		if (kind) begin
			op_in = OP_TRANSFORM;
		end else if (first_vertex) begin
			op_in = OP_RESTART;
		end else begin
			op_in = OP_EXTEND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q] <= op_in;
			px_q[wr_ptr_q] <= pos_x;
			py_q[wr_ptr_q] <= pos_y;
			pz_q[wr_ptr_q] <= pos_z;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.op    = op_q[rd_ptr_q];
	assign head_pos_x = px_q[rd_ptr_q];
	assign head_pos_y = py_q[rd_ptr_q];
	assign head_pos_z = pz_q[rd_ptr_q];

endmodule

[rtl/core/abt_back.sv]
// ----------------------------------------------------------------------------
// AABB back end
// Holds the running box, folds vertices into it and runs the box transform
// on two multipliers, one coefficient and one coordinate half per step.
// ----------------------------------------------------------------------------
module abt_back import abt_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  q_head_t                        head,
	input  logic signed [COORD_WIDTH-1:0]  head_pos_x,
	input  logic signed [COORD_WIDTH-1:0]  head_pos_y,
	input  logic signed [COORD_WIDTH-1:0]  head_pos_z,
	output logic                           pop,
	input  logic [CFG_WIDTH-1:0]           row_coeffs [AXES],
	input  logic signed [OFFSET_WIDTH-1:0] offsets [AXES],
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [COORD_WIDTH-1:0]  out_min_x,
	output logic signed [COORD_WIDTH-1:0]  out_min_y,
	output logic signed [COORD_WIDTH-1:0]  out_min_z,
	output logic signed [COORD_WIDTH-1:0]  out_max_x,
	output logic signed [COORD_WIDTH-1:0]  out_max_y,
	output logic signed [COORD_WIDTH-1:0]  out_max_z
);

	localparam int HALF_W     = COORD_WIDTH / 2;
	localparam int MUL_A_W    = HALF_W + 1;
	localparam int PROD_W     = MUL_A_W + COEF_WIDTH;
	localparam int FULL_W     = COORD_WIDTH + COEF_WIDTH;
	localparam int FRAC_SHIFT = COEF_WIDTH - 2;
	localparam int ACC_W      =
		((COORD_WIDTH + 1 > OFFSET_WIDTH) ? COORD_WIDTH + 1 : OFFSET_WIDTH) + 3;

	localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

	localparam logic signed [COORD_WIDTH-1:0] BOX_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] BOX_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ACC_MAX =
		{{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN =
		{{(ACC_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic [1:0] row_cnt_q;
	logic [1:0] col_cnt_q;
	logic       half_q;

	logic signed [COORD_WIDTH-1:0] lo_q [AXES];
	logic signed [COORD_WIDTH-1:0] hi_q [AXES];
	logic signed [COORD_WIDTH-1:0] nlo_q [AXES];
	logic signed [COORD_WIDTH-1:0] nhi_q [AXES];
	logic signed [COORD_WIDTH-1:0] omin_q [AXES];
	logic signed [COORD_WIDTH-1:0] omax_q [AXES];
	logic                          out_valid_q;

	logic signed [COORD_WIDTH-1:0] pos [AXES];
	logic signed [COORD_WIDTH-1:0] vlo [AXES];
	logic signed [COORD_WIDTH-1:0] vhi [AXES];

	// Multiply step signals.
	logic [CFG_WIDTH+COEF_WIDTH-1:0] row_ext;
	logic signed [COEF_WIDTH-1:0]    coef;
	logic signed [MUL_A_W-1:0]       opa_lo;
	logic signed [MUL_A_W-1:0]       opa_hi;
	logic signed [PROD_W-1:0]        prod_lo_c;
	logic signed [PROD_W-1:0]        prod_hi_c;

	// Stage one: registered products and their step tags.
	logic signed [PROD_W-1:0] prod_lo_s1;
	logic signed [PROD_W-1:0] prod_hi_s1;
	logic                     valid_s1;
	logic                     upper_s1;
	logic                     first_col_s1;
	logic                     last_col_s1;
	logic [1:0]               row_s1;

	// Stage two: recombine halves, scale, sort and accumulate.
	logic signed [FULL_W-1:0] part_lo_q;
	logic signed [FULL_W-1:0] part_hi_q;
	logic signed [FULL_W-1:0] full_lo;
	logic signed [FULL_W-1:0] full_hi;
	logic signed [FULL_W-1:0] shr_lo;
	logic signed [FULL_W-1:0] shr_hi;
	logic signed [ACC_W-1:0]  sc_lo;
	logic signed [ACC_W-1:0]  sc_hi;
	logic signed [ACC_W-1:0]  small_v;
	logic signed [ACC_W-1:0]  big_v;
	logic signed [ACC_W-1:0]  base_min;
	logic signed [ACC_W-1:0]  base_max;
	logic signed [ACC_W-1:0]  sum_min;
	logic signed [ACC_W-1:0]  sum_max;
	logic signed [ACC_W-1:0]  acc_min_q;
	logic signed [ACC_W-1:0]  acc_max_q;

	function automatic logic signed [MUL_A_W-1:0] half_sel(
		input logic signed [COORD_WIDTH-1:0] v,
		input logic                          upper
	);
		if (upper) begin
			return MUL_A_W'($signed(v[COORD_WIDTH-1:HALF_W]));
		end
		return $signed({1'b0, v[HALF_W-1:0]});
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [ACC_W-1:0] v);
		if (v > ACC_MAX) begin
			return BOX_MAX;
		end
		if (v < ACC_MIN) begin
			return BOX_MIN;
		end
		return v[COORD_WIDTH-1:0];
	endfunction

	assign pos[0] = head_pos_x;
	assign pos[1] = head_pos_y;
	assign pos[2] = head_pos_z;

	assign pop = (state_q == ST_IDLE) && head.valid;

	// Vertex fold: a restarting vertex compares against the empty box.
	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			logic signed [COORD_WIDTH-1:0] base_lo;
			logic signed [COORD_WIDTH-1:0] base_hi;
			base_lo = (head.op == OP_RESTART) ? BOX_MAX : lo_q[k];
			base_hi = (head.op == OP_RESTART) ? BOX_MIN : hi_q[k];
			vlo[k]  = (pos[k] < base_lo) ? pos[k] : base_lo;
			vhi[k]  = (pos[k] > base_hi) ? pos[k] : base_hi;
		end
	end

	// Coefficient (row, col) sits at bit COEF_STRIDE*col; bits past the
	// register read as zero.
	assign row_ext   = {{COEF_WIDTH{1'b0}}, row_coeffs[row_cnt_q]};
	assign coef      = row_ext[COEF_STRIDE * col_cnt_q +: COEF_WIDTH];
	assign opa_lo    = half_sel(lo_q[col_cnt_q], half_q);
	assign opa_hi    = half_sel(hi_q[col_cnt_q], half_q);
	assign prod_lo_c = opa_lo * coef;
	assign prod_hi_c = opa_hi * coef;

	always_comb begin
		full_lo  = (FULL_W'(prod_lo_s1) <<< HALF_W) + part_lo_q;
		full_hi  = (FULL_W'(prod_hi_s1) <<< HALF_W) + part_hi_q;
		shr_lo   = full_lo >>> FRAC_SHIFT;
		shr_hi   = full_hi >>> FRAC_SHIFT;
		sc_lo    = ACC_W'(shr_lo);
		sc_hi    = ACC_W'(shr_hi);
		small_v  = (sc_lo < sc_hi) ? sc_lo : sc_hi;
		big_v    = (sc_lo < sc_hi) ? sc_hi : sc_lo;
		base_min = first_col_s1 ? ACC_W'(offsets[row_s1]) : acc_min_q;
		base_max = first_col_s1 ? ACC_W'(offsets[row_s1]) : acc_max_q;
		sum_min  = base_min + small_v;
		sum_max  = base_max + big_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			upper_s1     <= 1'b0;
			first_col_s1 <= 1'b0;
			last_col_s1  <= 1'b0;
			row_s1       <= '0;
		end else begin
			valid_s1     <= (state_q == ST_MUL);
			upper_s1     <= half_q;
			first_col_s1 <= (col_cnt_q == '0);
			last_col_s1  <= (col_cnt_q == LAST_AXIS);
			row_s1       <= row_cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_lo_s1 <= prod_lo_c;
		prod_hi_s1 <= prod_hi_c;
		if (valid_s1) begin
			if (!upper_s1) begin
				part_lo_q <= FULL_W'(prod_lo_s1);
				part_hi_q <= FULL_W'(prod_hi_s1);
			end else if (last_col_s1) begin
				nlo_q[row_s1] <= sat(sum_min);
				nhi_q[row_s1] <= sat(sum_max);
			end else begin
				acc_min_q <= sum_min;
				acc_max_q <= sum_max;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_cnt_q   <= '0;
			col_cnt_q   <= '0;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < AXES; k++) begin
				lo_q[k]   <= BOX_MAX;
				hi_q[k]   <= BOX_MIN;
				omin_q[k] <= '0;
				omax_q[k] <= '0;
			end
		end else begin
			// In the commit state the valid flag is owned by the commit itself.
			if (out_valid_q && out_ready && (state_q != ST_COMMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						if (head.op == OP_TRANSFORM) begin
							row_cnt_q <= '0;
							col_cnt_q <= '0;
							half_q    <= 1'b0;
							state_q   <= ST_MUL;
						end else begin
							for (int k = 0; k < AXES; k++) begin
								lo_q[k] <= vlo[k];
								hi_q[k] <= vhi[k];
							end
						end
					end
				end
				ST_MUL: begin
					half_q <= !half_q;
					if (half_q) begin
						if (col_cnt_q == LAST_AXIS) begin
							col_cnt_q <= '0;
							row_cnt_q <= row_cnt_q + 1'b1;
							if (row_cnt_q == LAST_AXIS) begin
								state_q <= ST_DRAIN;
							end
						end else begin
							col_cnt_q <= col_cnt_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (!out_valid_q || out_ready) begin
						for (int k = 0; k < AXES; k++) begin
							lo_q[k]   <= nlo_q[k];
							hi_q[k]   <= nhi_q[k];
							omin_q[k] <= nlo_q[k];
							omax_q[k] <= nhi_q[k];
						end
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_min_x = omin_q[0];
	assign out_min_y = omin_q[1];
	assign out_min_z = omin_q[2];
	assign out_max_x = omax_q[0];
	assign out_max_y = omax_q[1];
	assign out_max_z = omax_q[2];

endmodule

[rtl/core/aabb_build_and_transform.sv]
// ----------------------------------------------------------------------------
// AABB build and transform
// Running axis-aligned box over a vertex stream, mapped through a
// configurable affine transform by the interval method on request.
// ----------------------------------------------------------------------------
// A vertex request (kind 0) widens the stored box by its position; with
// first_vertex set the box is emptied first. A transform request (kind 1)
// maps the stored box through the 3x3 coefficient matrix plus offsets: for
// each output axis the offset is added to the smaller of c*min and c*max for
// every input axis to form the new minimum, and the larger to form the new
// maximum. Products are floored to coordinate precision and the sums
// saturate. The new box replaces the stored one and is returned as one
// result; vertex requests return nothing. Requests enter a four-entry queue
// that the back end drains in order. The back end folds in a vertex request
// while idle, so vertices stream at one per cycle unless a transform holds
// it. A transform request leaves the queue, then applies nine coefficients,
// each to both halves of the coordinates on a pair of multipliers (18 steps),
// drains the product register and commits; the commit waits while an
// earlier result is still pending on the output. The configuration
// registers are written through a plain write port and should only change
// while no request is in flight.
// ----------------------------------------------------------------------------
module aabb_build_and_transform import abt_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [CFG_WIDTH-1:0]          cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic                          first_vertex,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] out_min_x,
	output logic signed [COORD_WIDTH-1:0] out_min_y,
	output logic signed [COORD_WIDTH-1:0] out_min_z,
	output logic signed [COORD_WIDTH-1:0] out_max_x,
	output logic signed [COORD_WIDTH-1:0] out_max_y,
	output logic signed [COORD_WIDTH-1:0] out_max_z
);

	// Coefficient rows hold three signed fixed-point values at 16-bit spacing,
	// column 0 lowest. After reset the matrix is the identity.
	logic [CFG_WIDTH-1:0]           row_q [AXES];
	logic signed [OFFSET_WIDTH-1:0] offset_q [AXES];

	q_head_t                       head;
	logic signed [COORD_WIDTH-1:0] head_pos_x;
	logic signed [COORD_WIDTH-1:0] head_pos_y;
	logic signed [COORD_WIDTH-1:0] head_pos_z;
	logic                          pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < AXES; k++) begin
				row_q[k]    <= CFG_WIDTH'(1) << (COEF_STRIDE * k + COEF_WIDTH - 2);
				offset_q[k] <= '0;
			end
		end else if (cfg_wr_en) begin
			// Writes to indexes past the offset registers are dropped.
			case (cfg_index)
				REG_ROW_X:    row_q[0]    <= cfg_data;
				REG_ROW_Y:    row_q[1]    <= cfg_data;
				REG_ROW_Z:    row_q[2]    <= cfg_data;
				REG_OFFSET_X: offset_q[0] <= cfg_data[OFFSET_WIDTH-1:0];
				REG_OFFSET_Y: offset_q[1] <= cfg_data[OFFSET_WIDTH-1:0];
				REG_OFFSET_Z: offset_q[2] <= cfg_data[OFFSET_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Front end: takes requests and queues them by class.
	abt_front #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.first_vertex (first_vertex),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.head         (head),
		.head_pos_x   (head_pos_x),
		.head_pos_y   (head_pos_y),
		.head_pos_z   (head_pos_z),
		.pop          (pop)
	);

	// Back end: owns the box and the transform datapath.
	abt_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_pos_x (head_pos_x),
		.head_pos_y (head_pos_y),
		.head_pos_z (head_pos_z),
		.pop        (pop),
		.row_coeffs (row_q),
		.offsets    (offset_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_min_x  (out_min_x),
		.out_min_y  (out_min_y),
		.out_min_z  (out_min_z),
		.out_max_x  (out_max_x),
		.out_max_y  (out_max_y),
		.out_max_z  (out_max_z)
	);

endmodule

[rtl/core/abt_checker.sv]
// ----------------------------------------------------------------------------
// AABB build and transform: port checker
// Watches the top-level ports for reset behavior, queue back-pressure and
// result hold under stall.
// ----------------------------------------------------------------------------
module abt_checker import abt_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [COORD_WIDTH-1:0] out_min_x,
	input logic signed [COORD_WIDTH-1:0] out_min_y,
	input logic signed [COORD_WIDTH-1:0] out_min_z,
	input logic signed [COORD_WIDTH-1:0] out_max_x,
	input logic signed [COORD_WIDTH-1:0] out_max_y,
	input logic signed [COORD_WIDTH-1:0] out_max_z
);

	// In reset no result is offered and the queue is open.
	a_reset_state: assert property (@(posedge clk)
		!arst_n |-> !out_valid && in_ready)
		else $error("result offered or queue closed during reset");

	// The queue only fills up as a consequence of a request taken the cycle before.
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("in_ready dropped without an accepted request");

	// A stalled result stays offered with the same box.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_min_x) && $stable(out_min_y)
			&& $stable(out_min_z) && $stable(out_max_x) && $stable(out_max_y)
			&& $stable(out_max_z))
		else $error("stalled result changed or was withdrawn");

endmodule

bind aabb_build_and_transform abt_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_abt_checker (.*);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the AABB build and transform block
// Streams vertex and transform requests through the block under a series of
// coefficient and offset settings. A scoreboard class keeps its own copy of
// the box and the registers, predicts each transformed box and compares every
// returned box field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
import abt_pkg::*;

localparam logic KIND_VERTEX    = 1'b0;
localparam logic KIND_TRANSFORM = 1'b1;

localparam int COORD_W   = COORD_WIDTH_DEF;
localparam int COEF_W    = COEF_WIDTH_DEF;
localparam int FRAC_BITS = COEF_W - 2;

localparam longint COORD_TOP    = (longint'(1) <<< (COORD_W - 1)) - 1;
localparam longint COORD_BOTTOM = -COORD_TOP - 1;

// Register indexes past the end of the list; writes to them must be dropped.
localparam logic [CFG_INDEX_WIDTH-1:0] IDX_SPARE_A = 3'd6;
localparam logic [CFG_INDEX_WIDTH-1:0] IDX_SPARE_B = 3'd7;

typedef struct packed {
	logic [AXES-1:0][COORD_W-1:0] lo;
	logic [AXES-1:0][COORD_W-1:0] hi;
} box_t;

class box_tracker;
	logic [CFG_WIDTH-1:0]      row_coef [AXES];
	logic signed [COORD_W-1:0] offset [AXES];
	logic signed [COORD_W-1:0] lo [AXES];
	logic signed [COORD_W-1:0] hi [AXES];
	box_t                      pending_boxes [$];
	int unsigned               mismatches;
	int unsigned               boxes_checked;
	string                     axis_name [AXES];

	function new();
		axis_name = '{"x", "y", "z"};
		mismatches = 0;
		boxes_checked = 0;
		row_coef[0] = CFG_WIDTH'(1) << FRAC_BITS;
		row_coef[1] = CFG_WIDTH'(1) << (FRAC_BITS + COEF_STRIDE);
		row_coef[2] = CFG_WIDTH'(1) << (FRAC_BITS + 2 * COEF_STRIDE);
		for (int k = 0; k < AXES; k++) offset[k] = '0;
		empty_box();
	endfunction

	function void empty_box();
		for (int k = 0; k < AXES; k++) begin
			lo[k] = COORD_W'(COORD_TOP);
			hi[k] = COORD_W'(COORD_BOTTOM);
		end
	endfunction

	function void write_reg(logic [CFG_INDEX_WIDTH-1:0] index, logic [CFG_WIDTH-1:0] data);
		case (index)
			REG_ROW_X, REG_ROW_Y, REG_ROW_Z: row_coef[index] = data;
			REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z:
				offset[index - REG_OFFSET_X] = data[OFFSET_WIDTH-1:0];
			default: ;
		endcase
	endfunction

	// Exact product, floored back to coordinate precision.
	function longint scaled(longint p, longint c);
		longint prod;
		prod = p * c;
		return prod >>> FRAC_BITS;
	endfunction

	function logic [COORD_W-1:0] clamp(longint v);
		if (v > COORD_TOP) return COORD_W'(COORD_TOP);
		if (v < COORD_BOTTOM) return COORD_W'(COORD_BOTTOM);
		return COORD_W'(v);
	endfunction

	// Called for every accepted request.
	function void note_request(logic kind_i, logic first_i, logic [AXES-1:0][COORD_W-1:0] pos);
		logic signed [COORD_W-1:0] p;
		longint c, a, b, smin, smax;
		box_t nbox;
		if (kind_i == KIND_VERTEX) begin
			if (first_i) empty_box();
			for (int j = 0; j < AXES; j++) begin
				p = pos[j];
				if (p < lo[j]) lo[j] = p;
				if (p > hi[j]) hi[j] = p;
			end
			return;
		end
		for (int i = 0; i < AXES; i++) begin
			smin = longint'(offset[i]);
			smax = smin;
			for (int j = 0; j < AXES; j++) begin
				c = longint'($signed(row_coef[i][COEF_STRIDE*j +: COEF_W]));
				a = scaled(longint'(lo[j]), c);
				b = scaled(longint'(hi[j]), c);
				if (a < b) begin
					smin += a;
					smax += b;
				end else begin
					smin += b;
					smax += a;
				end
			end
			nbox.lo[i] = clamp(smin);
			nbox.hi[i] = clamp(smax);
		end
		for (int i = 0; i < AXES; i++) begin
			lo[i] = nbox.lo[i];
			hi[i] = nbox.hi[i];
		end
		pending_boxes.push_back(nbox);
	endfunction

	// Called for every accepted result.
	function void check_box(box_t got);
		box_t want;
		if (pending_boxes.size() == 0) begin
			$display("%0t: box returned with none expected", $time);
			mismatches++;
			return;
		end
		want = pending_boxes.pop_front();
		boxes_checked++;
		for (int k = 0; k < AXES; k++) begin
			if (got.lo[k] !== want.lo[k]) begin
				$display("%0t: out_min_%s expected %0d actual %0d", $time, axis_name[k],
					$signed(want.lo[k]), $signed(got.lo[k]));
				mismatches++;
			end
			if (got.hi[k] !== want.hi[k]) begin
				$display("%0t: out_max_%s expected %0d actual %0d", $time, axis_name[k],
					$signed(want.hi[k]), $signed(got.hi[k]));
				mismatches++;
			end
		end
	endfunction

	function int pending_count();
		return pending_boxes.size();
	endfunction
endclass

module tb;

	// The queue holds four requests, and this wait is long enough for any
	// vertex still draining out of it after the last transform.
	localparam int DRAIN_CYCLES  = 40;
	// The receiver's deliberate hold-off, long enough to fill the queue.
	localparam int HOLD_CYCLES   = 300;
	// Cycles without any handshake before the run is declared hung.
	localparam int STALL_LIMIT   = 3000;
	localparam int PHASE_ITEMS   = 300;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_WIDTH-1:0]       cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic                       kind;
	logic                       first_vertex;
	logic signed [COORD_W-1:0]  pos_x;
	logic signed [COORD_W-1:0]  pos_y;
	logic signed [COORD_W-1:0]  pos_z;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [COORD_W-1:0]  out_min_x;
	logic signed [COORD_W-1:0]  out_min_y;
	logic signed [COORD_W-1:0]  out_min_z;
	logic signed [COORD_W-1:0]  out_max_x;
	logic signed [COORD_W-1:0]  out_max_y;
	logic signed [COORD_W-1:0]  out_max_z;

	box_tracker tracker;

	// Idling controls shared between the driving processes.
	bit sender_idles;
	bit receiver_stalls;
	bit hold_off_request;

	int unsigned vertex_count;
	int unsigned transform_count;
	int unsigned setting_count;
	int unsigned quiet_cycles;

	aabb_build_and_transform dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.first_vertex (first_vertex),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_min_x    (out_min_x),
		.out_min_y    (out_min_y),
		.out_min_z    (out_min_z),
		.out_max_x    (out_max_x),
		.out_max_y    (out_max_y),
		.out_max_z    (out_max_z)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: any accepted request or result restarts the count. A hang in
	// the block, or a lost result at the end, runs it out.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side. Every box accepted at an edge is handed to the scoreboard,
	// then out_ready for the next edge is chosen. A hold-off request from the
	// stimulus keeps out_ready low for a long stretch counted right here.
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				tracker.check_box({out_min_z, out_min_y, out_min_x,
					out_max_z, out_max_y, out_max_x});
			end
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= !(receiver_stalls && ($urandom_range(99) < 30));
			end
		end
	end

	// Offers one request and returns at the edge where it is accepted. It is
	// always entered right after a rising edge, so valid only ever gets one
	// assignment per step and stays high between back-to-back requests.
	task automatic offer_request(logic k, logic f, logic [AXES-1:0][COORD_W-1:0] pos);
		while (sender_idles && ($urandom_range(99) < 30)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		first_vertex <= f;
		pos_x        <= pos[0];
		pos_y        <= pos[1];
		pos_z        <= pos[2];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_request(k, f, pos);
		if (k == KIND_VERTEX) vertex_count++;
		else transform_count++;
	endtask

	// Drops valid, waits for every predicted box, then lets any trailing
	// vertices drain out of the queue so the registers can be changed safely.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_count() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] index, logic [CFG_WIDTH-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		tracker.write_reg(index, data);
	endtask

	// Loads a full setting. The offsets carry junk in the bits above 32 and the
	// two spare indexes get random writes that must have no effect.
	task automatic load_setting(logic [CFG_WIDTH-1:0] rx, logic [CFG_WIDTH-1:0] ry,
			logic [CFG_WIDTH-1:0] rz, logic [OFFSET_WIDTH-1:0] ox,
			logic [OFFSET_WIDTH-1:0] oy, logic [OFFSET_WIDTH-1:0] oz);
		write_reg(IDX_SPARE_A, {16'($urandom), 32'($urandom)});
		write_reg(REG_ROW_X, rx);
		write_reg(REG_ROW_Y, ry);
		write_reg(REG_ROW_Z, rz);
		write_reg(REG_OFFSET_X, {16'($urandom), ox});
		write_reg(REG_OFFSET_Y, {16'($urandom), oy});
		write_reg(REG_OFFSET_Z, {16'($urandom), oz});
		write_reg(IDX_SPARE_B, {16'($urandom), 32'($urandom)});
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		setting_count++;
	endtask

	// Coordinates lean toward small values so that most boxes stay in range,
	// with the extremes and full-width values mixed in.
	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(9))
			0: return COORD_W'(COORD_TOP);
			1: return COORD_W'(COORD_BOTTOM);
			2, 3, 4: return COORD_W'($urandom);
			default: return COORD_W'($urandom_range(32'h1f_ffff)) - 32'h10_0000;
		endcase
	endfunction

	function automatic logic [AXES-1:0][COORD_W-1:0] pick_pos();
		return {pick_coord(), pick_coord(), pick_coord()};
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'h4000;
			4: return 16'hc000;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_WIDTH-1:0] pick_row();
		return {pick_coef(), pick_coef(), pick_coef()};
	endfunction

	// Mostly well-formed runs: a first vertex, a few more vertices, then one or
	// two transforms. The rest is loose requests with every field random.
	task automatic random_phase(int n_items);
		int sent;
		int run;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 85) begin
				run = $urandom_range(1, 8);
				offer_request(KIND_VERTEX, 1'b1, pick_pos());
				for (int v = 1; v < run; v++) offer_request(KIND_VERTEX, 1'b0, pick_pos());
				offer_request(KIND_TRANSFORM, 1'($urandom), pick_pos());
				sent += run + 1;
				if ($urandom_range(99) < 20) begin
					offer_request(KIND_TRANSFORM, 1'($urandom), pick_pos());
					sent++;
				end
			end else begin
				offer_request(1'($urandom), 1'($urandom), pick_pos());
				sent++;
			end
		end
	endtask

	initial begin
		logic [AXES-1:0][COORD_W-1:0] top_pos;
		logic [AXES-1:0][COORD_W-1:0] bottom_pos;

		tracker = new();
		top_pos = {3{COORD_W'(COORD_TOP)}};
		bottom_pos = {3{COORD_W'(COORD_BOTTOM)}};
		vertex_count = 0;
		transform_count = 0;
		setting_count = 1;
		quiet_cycles = 0;
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
		hold_off_request = 1'b0;

		arst_n       <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		kind         <= KIND_VERTEX;
		first_vertex <= 1'b0;
		pos_x        <= '0;
		pos_y        <= '0;
		pos_z        <= '0;
		out_ready    <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset setting (identity, no offset). The
		// first transform sees the empty box straight out of reset, with junk
		// in the fields that a transform ignores.
		offer_request(KIND_TRANSFORM, 1'b1, top_pos);
		offer_request(KIND_TRANSFORM, 1'b0, bottom_pos);
		offer_request(KIND_VERTEX, 1'b1, top_pos);
		offer_request(KIND_VERTEX, 1'b0, bottom_pos);
		offer_request(KIND_VERTEX, 1'b0, '0);
		offer_request(KIND_VERTEX, 1'b0, {3{32'hffff_ffff}});
		offer_request(KIND_TRANSFORM, 1'b0, '0);
		offer_request(KIND_VERTEX, 1'b1, {32'h0001_0000, 32'hfffe_8000, 32'h0000_0001});
		offer_request(KIND_VERTEX, 1'b0, {32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0000});
		offer_request(KIND_TRANSFORM, 1'b1, {3{32'haaaa_aaaa}});
		// A vertex without the first flag widens the transformed box.
		offer_request(KIND_VERTEX, 1'b0, {32'h0000_0100, 32'hffff_ff00, 32'h0000_0000});
		offer_request(KIND_TRANSFORM, 1'b0, {3{32'h5555_5555}});
		settle();

		// Most negative coefficients and offsets: sums pin at the bottom and
		// the sign flip of each product swaps min and max.
		load_setting({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
			COORD_W'(COORD_BOTTOM), COORD_W'(COORD_BOTTOM), COORD_W'(COORD_BOTTOM));
		offer_request(KIND_TRANSFORM, 1'b0, '0);
		offer_request(KIND_VERTEX, 1'b1, top_pos);
		offer_request(KIND_VERTEX, 1'b0, {32'h0000_0010, 32'hffff_fff0, 32'h0001_0000});
		offer_request(KIND_TRANSFORM, 1'b0, '0);
		offer_request(KIND_VERTEX, 1'b1, {32'h0000_0003, 32'hffff_fffd, 32'h0000_0001});
		offer_request(KIND_TRANSFORM, 1'b0, '0);
		settle();

		// Most positive coefficients and offsets: sums pin at the top.
		load_setting({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}},
			COORD_W'(COORD_TOP), COORD_W'(COORD_TOP), COORD_W'(COORD_TOP));
		offer_request(KIND_VERTEX, 1'b1, bottom_pos);
		offer_request(KIND_TRANSFORM, 1'b0, '0);
		offer_request(KIND_VERTEX, 1'b1, {32'hffff_fffd, 32'h0000_0007, 32'h0000_0000});
		offer_request(KIND_TRANSFORM, 1'b0, '0);
		offer_request(KIND_TRANSFORM, 1'b1, top_pos);
		settle();

		// Random phases. The first runs with no idling on either side at all;
		// the second starts with the receiver holding off for a long stretch
		// while requests keep coming, so the queue fills and in_ready drops.
		load_setting(pick_row(), pick_row(), pick_row(), $urandom, $urandom, $urandom);
		sender_idles = 1'b0;
		receiver_stalls = 1'b0;
		random_phase(PHASE_ITEMS);
		settle();
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;

		load_setting(pick_row(), pick_row(), pick_row(),
			pick_coord(), pick_coord(), pick_coord());
		hold_off_request = 1'b1;
		random_phase(PHASE_ITEMS);
		settle();

		load_setting({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
			COORD_W'(COORD_BOTTOM), COORD_W'(COORD_TOP), COORD_W'(COORD_BOTTOM));
		random_phase(PHASE_ITEMS);
		settle();

		load_setting({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}},
			COORD_W'(COORD_TOP), COORD_W'(COORD_BOTTOM), COORD_W'(COORD_TOP));
		random_phase(PHASE_ITEMS);
		settle();

		// Zero matrix: every box collapses onto the offsets.
		load_setting('0, '0, '0, $urandom, $urandom, $urandom);
		random_phase(PHASE_ITEMS);
		settle();

		load_setting(pick_row(), pick_row(), pick_row(),
			pick_coord(), pick_coord(), pick_coord());
		random_phase(PHASE_ITEMS);
		settle();

		$display("Run covered %0d vertex and %0d transform requests over %0d register settings.",
			vertex_count, transform_count, setting_count);
		$display("Boxes compared: %0d, field mismatches: %0d.",
			tracker.boxes_checked, tracker.mismatches);
		if (tracker.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
